>>> rtl/core/fip_pkg.sv
`timescale 1ns / 1ps

package fip_pkg;

    // Field widths of the item and result channels
    localparam int MODE_W   = 1;
    localparam int INDEX_W  = 5;
    localparam int COEF_W   = 18;
    localparam int SAMPLE_W = 16;
    localparam int VALUE_W  = 32;
    localparam int PROD_W   = COEF_W + SAMPLE_W;

    // Default configuration
    localparam int TAPS_DEF        = 31;
    localparam int UP_FACTOR_DEF   = 2;
    localparam int SAMPLE_BITS_DEF = 16;

    // Item mode codes
    localparam logic [MODE_W-1:0] MODE_LOAD   = 1'b0;
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic coef_wr;     // write the coefficient of the accepted item
        logic shift_hist;  // push the accepted sample into the history
        logic issue;       // start one tap product
        logic first;       // this tap opens a phase sum
        logic last_tap;    // this tap closes a phase sum
        logic clr_acc;     // phase with no taps: present a zero sum
        logic load_out;    // move the finished sum to the output register
        logic out_last;    // the loaded sum is the final phase
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic acc_full;    // a finished phase sum waits
        logic out_free;    // the output register can take a result now
    } t_status;

endpackage

>>> rtl/core/fip_ram.sv
`timescale 1ns / 1ps

module fip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/fip_datapath.sv
`timescale 1ns / 1ps

module fip_datapath #(
    parameter int TAPS        = fip_pkg::TAPS_DEF,
    parameter int UP_FACTOR   = fip_pkg::UP_FACTOR_DEF,
    parameter int SAMPLE_BITS = fip_pkg::SAMPLE_BITS_DEF,
    parameter int HIST        = (TAPS + UP_FACTOR - 1) / UP_FACTOR,
    parameter int AW          = $clog2(TAPS),
    parameter int HW          = (HIST > 1) ? $clog2(HIST) : 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fip_pkg::t_cmd                        i_cmd,
    input  logic [AW-1:0]                        i_rd_addr,
    input  logic [HW-1:0]                        i_hist_sel,
    input  logic [fip_pkg::INDEX_W-1:0]          i_coef_index,
    input  logic signed [fip_pkg::COEF_W-1:0]    i_coef_value,
    input  logic signed [fip_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                                 i_out_stall,
    output fip_pkg::t_status                     o_status,
    output logic                                 o_out_valid,
    output logic signed [fip_pkg::VALUE_W-1:0]   o_value,
    output logic                                 o_last
);

    localparam int SHIFT = SAMPLE_BITS - 1;

    logic [fip_pkg::COEF_W-1:0]               coef_q;
    logic signed [fip_pkg::SAMPLE_W-1:0]      r_hist [HIST];
    logic                                     r_s1_valid, r_s1_first, r_s1_last;
    logic signed [fip_pkg::SAMPLE_W-1:0]      r_s1_hist;
    logic                                     r_s2_valid, r_s2_first, r_s2_last;
    logic signed [fip_pkg::PROD_W-1:0]        r_prod;
    logic signed [fip_pkg::PROD_W-1:0]        prod_sh;
    logic signed [fip_pkg::VALUE_W-1:0]       term;
    logic signed [fip_pkg::VALUE_W-1:0]       r_acc, n_acc;
    logic                                     r_acc_full;
    logic                                     r_out_valid, r_out_last;
    logic signed [fip_pkg::VALUE_W-1:0]       r_out_value;

    fip_ram #(
        .WIDTH (fip_pkg::COEF_W),
        .DEPTH (TAPS),
        .AW    (AW)
    ) u_coef_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.coef_wr),
        .i_wr_addr (AW'(i_coef_index)),
        .i_wr_data (i_coef_value),
        .i_rd_en   (i_cmd.issue),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (coef_q)
    );

    // Sample history, newest at index 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_cmd.shift_hist) begin
            r_hist[0] <= i_sample;
            for (int i = 1; i < HIST; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    // Stage 1: coefficient read, history tap captured
    always_ff @(posedge i_clk) begin
        r_s1_hist  <= r_hist[i_hist_sel];
        r_s1_first <= i_cmd.first;
        r_s1_last  <= i_cmd.last_tap;
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue;
        end
    end

    // Stage 2: product
    always_ff @(posedge i_clk) begin
        r_prod     <= $signed(coef_q) * r_s1_hist;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // Floor shift of the product, then wrap to the result width
    assign prod_sh = r_prod >>> SHIFT;
    assign term    = fip_pkg::VALUE_W'(prod_sh);
    assign n_acc   = r_s2_first ? term : r_acc + term;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_acc) begin
            r_acc <= '0;
        end else if (r_s2_valid) begin
            r_acc <= n_acc;
        end
        if (!i_rst_n) begin
            r_acc_full <= 1'b0;
        end else if (i_cmd.clr_acc) begin
            r_acc_full <= 1'b1;
        end else if (r_s2_valid && r_s2_last) begin
            r_acc_full <= 1'b1;
        end else if (i_cmd.load_out) begin
            r_acc_full <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_value <= r_acc;
            r_out_last  <= i_cmd.out_last;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.acc_full = r_acc_full;
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_value           = r_out_value;
    assign o_last            = r_out_last;

endmodule

>>> rtl/core/fip_ctrl.sv
`timescale 1ns / 1ps

module fip_ctrl #(
    parameter int TAPS      = fip_pkg::TAPS_DEF,
    parameter int UP_FACTOR = fip_pkg::UP_FACTOR_DEF,
    parameter int HIST      = (TAPS + UP_FACTOR - 1) / UP_FACTOR,
    parameter int AW        = $clog2(TAPS),
    parameter int HW        = (HIST > 1) ? $clog2(HIST) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic [fip_pkg::MODE_W-1:0]      i_mode,
    input  logic [fip_pkg::INDEX_W-1:0]     i_coef_index,
    input  fip_pkg::t_status                i_status,
    output logic                            o_in_stall,
    output fip_pkg::t_cmd                   o_cmd,
    output logic [AW-1:0]                   o_rd_addr,
    output logic [HW-1:0]                   o_hist_sel
);

    localparam int KW = $clog2(TAPS + UP_FACTOR);
    localparam int PW = $clog2(UP_FACTOR);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [KW-1:0] r_k, n_k;
    logic [HW-1:0] r_h, n_h;
    logic [PW-1:0] r_p, n_p;
    logic          accept;
    logic          last_tap;
    logic          last_phase;
    logic [KW-1:0] next_k;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign last_tap   = ((KW + 1)'(r_k) + (KW + 1)'(UP_FACTOR)) >= (KW + 1)'(TAPS);
    assign last_phase = (r_p == PW'(UP_FACTOR - 1));
    assign next_k     = KW'(r_p) + KW'(1);

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_h     = r_h;
        n_p     = r_p;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_mode == fip_pkg::MODE_SAMPLE) begin
                        o_cmd.shift_hist = 1'b1;
                        n_state = S_RUN;
                        n_k     = '0;
                        n_h     = '0;
                        n_p     = '0;
                    end else begin
                        o_cmd.coef_wr = (32'(i_coef_index) < 32'(TAPS));
                    end
                end
            end
            S_RUN: begin
                o_cmd.issue    = 1'b1;
                o_cmd.first    = (r_h == '0);
                o_cmd.last_tap = last_tap;
                if (last_tap) begin
                    n_state = S_WAIT;
                end else begin
                    n_k = r_k + KW'(UP_FACTOR);
                    n_h = r_h + HW'(1);
                end
            end
            S_WAIT: begin
                if (i_status.acc_full && i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_last = last_phase;
                    if (last_phase) begin
                        n_state = S_IDLE;
                    end else begin
                        n_p = r_p + PW'(1);
                        n_k = next_k;
                        n_h = '0;
                        if (next_k >= KW'(TAPS)) begin
                            o_cmd.clr_acc = 1'b1;
                        end else begin
                            n_state = S_RUN;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_h     <= '0;
            r_p     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_h     <= n_h;
            r_p     <= n_p;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_rd_addr  = r_k[AW-1:0];
    assign o_hist_sel = r_h;

endmodule

>>> rtl/core/fixed_point_fir_interpolator.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                 Payload
// in       sink       i_in_valid / o_in_stall   i_mode, i_coef_index, i_coef_value, i_sample
// out      source     o_out_valid / i_out_stall o_value, o_last
//
// A coefficient load leaves the block idle and ready for the next item. After a sample, the input
// stalls until the result of every phase has been loaded into the output register:
// one shared multiply-accumulate unit works through the taps of each phase, one per cycle,
// then drains the read/multiply/accumulate pipe and loads the result of that phase.
// Reset is synchronous, active low, and clears control state and the sample history.
// A stalled result holds in the output register; the next phase waits for it to leave.

module fixed_point_fir_interpolator #(
    parameter int TAPS        = fip_pkg::TAPS_DEF,
    parameter int UP_FACTOR   = fip_pkg::UP_FACTOR_DEF,
    parameter int SAMPLE_BITS = fip_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [fip_pkg::MODE_W-1:0]           i_mode,
    input  logic [fip_pkg::INDEX_W-1:0]          i_coef_index,
    input  logic signed [fip_pkg::COEF_W-1:0]    i_coef_value,
    input  logic signed [fip_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [fip_pkg::VALUE_W-1:0]   o_value,
    output logic                                 o_last
);

    // History holds one sample per tap of the longest phase
    localparam int HIST = (TAPS + UP_FACTOR - 1) / UP_FACTOR;
    localparam int AW   = $clog2(TAPS);
    localparam int HW   = (HIST > 1) ? $clog2(HIST) : 1;

    fip_pkg::t_cmd    cmd;
    fip_pkg::t_status status;
    logic [AW-1:0]    rd_addr;
    logic [HW-1:0]    hist_sel;

    // Sequence loads, taps and phases
    fip_ctrl #(
        .TAPS      (TAPS),
        .UP_FACTOR (UP_FACTOR),
        .HIST      (HIST),
        .AW        (AW),
        .HW        (HW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_mode       (i_mode),
        .i_coef_index (i_coef_index),
        .i_status     (status),
        .o_in_stall   (o_in_stall),
        .o_cmd        (cmd),
        .o_rd_addr    (rd_addr),
        .o_hist_sel   (hist_sel)
    );

    // Coefficient memory, history, multiply-accumulate and output register
    fip_datapath #(
        .TAPS        (TAPS),
        .UP_FACTOR   (UP_FACTOR),
        .SAMPLE_BITS (SAMPLE_BITS),
        .HIST        (HIST),
        .AW          (AW),
        .HW          (HW)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_rd_addr    (rd_addr),
        .i_hist_sel   (hist_sel),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_sample     (i_sample),
        .i_out_stall  (i_out_stall),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .o_value      (o_value),
        .o_last       (o_last)
    );

endmodule
